@@ src/dc1d_pkg.sv @@
// Shared types and constants for the 1-D density clustering core.
// Item structs, register indexes, controller states and the control/status links.
// Depends on nothing.
`default_nettype none

package dc1d_pkg;

  // Function codes of an input item
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EPS         = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CORE_SIZE   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SORT_ENABLE = 2'd2;

  localparam logic [31:0] EPS_RESET         = 32'd0;
  localparam logic [10:0] CORE_SIZE_RESET   = 11'd2;
  localparam logic        SORT_ENABLE_RESET = 1'b1;

  // Label of a point that belongs to no cluster
  localparam int NOISE = 0;

  typedef struct packed {
    logic               func;
    logic signed [31:0] point_value;
    logic               last_point;
    logic [9:0]         query_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] label;
    logic [10:0] point_count;
    logic        overflowed;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_QUERY, S_START,
    S_SORT_SEG, S_SORT_RD, S_SORT_WR,
    S_UP_RD, S_UP_EV, S_LO_RD, S_LO_EV,
    S_CLR, S_SCAN_RD, S_SCAN_EV,
    S_GR_RD, S_GR_EV, S_GL_RD, S_GL_EV,
    S_RO_RD, S_RO_WR, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_QUERY, OP_EMIT_QUERY, OP_START,
    OP_SORT_SEG, OP_SORT_RD, OP_SORT_WR,
    OP_UP_RD, OP_UP_EV, OP_LO_RD, OP_LO_EV,
    OP_CLR, OP_SCAN_RD, OP_SCAN_EV,
    OP_GR_RD, OP_GR_EV, OP_GL_RD, OP_GL_EV,
    OP_RO_RD, OP_RO_WR, OP_EMIT_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic sort_go;    // sorting enabled and more than one point held
    logic sort_last;  // the merge pass now running is the final one
    logic k_end;      // sweep index reached the point count
    logic k_last;     // sweep index at the last point
    logic k_zero;     // sweep index at the first point
    logic up_step;    // upper scan pointer may advance
    logic lo_step;    // lower scan pointer may retreat
    logic visited;    // sorted label read back is already assigned
    logic core;       // point read back is a core point
    logic gr_go;      // right expansion continues
    logic gl_go;      // left expansion continues
    logic out_busy;   // output register holds an item not yet taken
  } status_t;

endpackage

`default_nettype wire

@@ src/dc1d_controller.sv @@
// Controller state machine of the 1-D density clustering core.
// Sequences load, query, merge sort, neighborhood scans, labeling and reorder.
// Depends on dc1d_pkg.
`default_nettype none

module dc1d_controller import dc1d_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    func,
  input  wire logic    last_point,
  input  wire status_t status,
  output logic         in_ready,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_QUERY) begin
            cmd.op     = OP_QUERY;
            state_next = S_QUERY;
          end else begin
            cmd.op     = OP_LOAD;
            state_next = last_point ? S_START : S_IDLE;
          end
        end
      end
      S_QUERY: begin
        if (!status.out_busy) begin
          cmd.op     = OP_EMIT_QUERY;
          state_next = S_IDLE;
        end
      end
      S_START: begin
        cmd.op     = OP_START;
        state_next = status.sort_go ? S_SORT_SEG : S_UP_RD;
      end
      S_SORT_SEG: begin
        cmd.op = OP_SORT_SEG;
        if (status.k_end) begin
          state_next = status.sort_last ? S_UP_RD : S_SORT_SEG;
        end else begin
          state_next = S_SORT_RD;
        end
      end
      S_SORT_RD: begin
        cmd.op     = OP_SORT_RD;
        state_next = S_SORT_WR;
      end
      S_SORT_WR: begin
        cmd.op     = OP_SORT_WR;
        state_next = S_SORT_SEG;
      end
      S_UP_RD: begin
        cmd.op     = OP_UP_RD;
        state_next = S_UP_EV;
      end
      S_UP_EV: begin
        cmd.op     = OP_UP_EV;
        state_next = (!status.up_step && status.k_last) ? S_LO_RD : S_UP_RD;
      end
      S_LO_RD: begin
        cmd.op     = OP_LO_RD;
        state_next = S_LO_EV;
      end
      S_LO_EV: begin
        cmd.op     = OP_LO_EV;
        state_next = (!status.lo_step && status.k_zero) ? S_CLR : S_LO_RD;
      end
      S_CLR: begin
        cmd.op     = OP_CLR;
        state_next = status.k_last ? S_SCAN_RD : S_CLR;
      end
      S_SCAN_RD: begin
        cmd.op     = OP_SCAN_RD;
        state_next = status.k_end ? S_RO_RD : S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.op     = OP_SCAN_EV;
        state_next = (status.visited || !status.core) ? S_SCAN_RD : S_GR_RD;
      end
      S_GR_RD: begin
        cmd.op     = OP_GR_RD;
        state_next = status.gr_go ? S_GR_EV : S_GL_RD;
      end
      S_GR_EV: begin
        cmd.op     = OP_GR_EV;
        state_next = S_GR_RD;
      end
      S_GL_RD: begin
        cmd.op     = OP_GL_RD;
        state_next = status.gl_go ? S_GL_EV : S_SCAN_RD;
      end
      S_GL_EV: begin
        cmd.op     = OP_GL_EV;
        state_next = S_GL_RD;
      end
      S_RO_RD: begin
        cmd.op     = OP_RO_RD;
        state_next = status.k_end ? S_DONE : S_RO_WR;
      end
      S_RO_WR: begin
        cmd.op     = OP_RO_WR;
        state_next = S_RO_RD;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.op     = OP_EMIT_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/dc1d_datapath.sv @@
// Datapath of the 1-D density clustering core: point, bound and label memories,
// sweep counters, distance and core-point tests, and the output register.
// Depends on dc1d_pkg.
`default_nettype none

module dc1d_datapath import dc1d_pkg::*; #(
  parameter int MAX_POINTS  = 1024,
  parameter int POINT_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmd_t     cmd,
  input  wire in_item_t in_data,
  input  wire logic [31:0] eps,
  input  wire logic [10:0] core_size,
  input  wire logic     sort_enable,
  input  wire logic     out_ready,
  output logic          out_valid,
  output out_item_t     out_data,
  output status_t       status
);

  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int WW   = CW + 2;
  localparam int LW   = CW + 1;
  localparam int PW   = POINT_WIDTH;
  localparam int DPW  = PW + 1;
  localparam int DW   = (DPW > 32) ? DPW : 32;
  localparam int HW   = ((IW > 11) ? IW : 11) + 2;
  localparam int PAIR = PW + IW;
  localparam logic [LW-1:0] UNSEEN    = '1;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_POINTS);

  // Memories: sort buffers hold {value, arrival index}
  logic [PAIR-1:0] buf_a [MAX_POINTS];
  logic [PAIR-1:0] buf_b [MAX_POINTS];
  logic [IW-1:0]   upper_mem [MAX_POINTS];
  logic [IW-1:0]   lower_mem [MAX_POINTS];
  logic [LW-1:0]   slab_mem  [MAX_POINTS];
  logic [CW-1:0]   olab_mem  [MAX_POINTS];

  logic [PAIR-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic [IW-1:0]   up_rd, lo_rd;
  logic [LW-1:0]   sl_rd;
  logic [CW-1:0]   ol_rd;

  // Control registers
  logic [CW-1:0] count, n, k, u, lp, i, j, mid, hi;
  logic [WW-1:0] w;
  logic          cur, ovf, set_done, qok;
  logic [IW-1:0] p, ru, rl;
  logic [LW-1:0] id;

  // Memory port controls
  logic [IW-1:0]   addr0, addr1;
  logic            a_we, b_we, up_we, lo_we, sl_we, ol_we;
  logic [IW-1:0]   a_wa, b_wa, sl_wa, ol_wa;
  logic [PAIR-1:0] a_wd, b_wd;
  logic [IW-1:0]   up_wd, lo_wd;
  logic [LW-1:0]   sl_wd;
  logic [CW-1:0]   ol_wd;

  logic [PAIR-1:0]       rd0, rd1;
  logic signed [PW-1:0]  va, vb, pv;
  logic signed [DPW-1:0] diff;
  logic [DPW-1:0]        mag;
  logic                  in_reach;
  logic [HW-1:0]         hs_raw;
  logic                  core;
  logic                  take_left;
  logic [CW-1:0]         cnt_eff;
  logic [WW-1:0]         mid_sum, hi_sum;
  logic [CW-1:0]         mid_c, hi_c;
  logic                  emit;

  assign rd0 = cur ? b_rd0 : a_rd0;
  assign rd1 = cur ? b_rd1 : a_rd1;
  assign va  = $signed(rd0[PAIR-1:IW]);
  assign vb  = $signed(rd1[PAIR-1:IW]);
  assign pv  = PW'(in_data.point_value);

  // Inclusive distance test
  assign diff     = DPW'(va) - DPW'(vb);
  assign mag      = diff[DPW-1] ? DPW'(-diff) : DPW'(diff);
  assign in_reach = DW'(mag) <= DW'(eps);

  // Neighborhood size, compared as a signed number
  assign hs_raw = HW'(up_rd) - HW'(lo_rd) + HW'(1);
  assign core   = $signed(hs_raw) >= $signed(HW'(core_size));

  // Stable merge: left run wins ties
  assign take_left = (i < mid) && ((j >= hi) || (va <= vb));

  assign cnt_eff = set_done ? '0 : count;
  assign mid_sum = WW'(k) + w;
  assign hi_sum  = WW'(k) + (w << 1);
  assign mid_c   = (mid_sum < WW'(n)) ? CW'(mid_sum) : n;
  assign hi_c    = (hi_sum < WW'(n)) ? CW'(hi_sum) : n;

  assign emit = (cmd.op == OP_EMIT_QUERY) || (cmd.op == OP_EMIT_DONE);

  always_comb begin
    status.sort_go   = sort_enable && (count > CW'(1));
    status.sort_last = (w << 1) >= WW'(n);
    status.k_end     = (k == n);
    status.k_last    = (k == n - CW'(1));
    status.k_zero    = (k == '0);
    status.up_step   = (u < n) && in_reach;
    status.lo_step   = (lp != '0) && in_reach;
    status.visited   = (sl_rd != UNSEEN);
    status.core      = core;
    status.gr_go     = (i < n) && (i <= CW'(ru));
    status.gl_go     = (j != '0) && ((j - CW'(1)) >= CW'(rl));
    status.out_busy  = out_valid && !out_ready;
  end

  // Read addresses
  always_comb begin
    unique case (cmd.op)
      OP_SORT_RD: begin
        addr0 = i[IW-1:0];
        addr1 = j[IW-1:0];
      end
      OP_LO_RD: begin
        addr0 = k[IW-1:0];
        addr1 = IW'(lp - CW'(1));
      end
      OP_GR_RD: begin
        addr0 = i[IW-1:0];
        addr1 = u[IW-1:0];
      end
      OP_GL_RD: begin
        addr0 = IW'(j - CW'(1));
        addr1 = u[IW-1:0];
      end
      default: begin
        addr0 = k[IW-1:0];
        addr1 = u[IW-1:0];
      end
    endcase
  end

  // Write ports
  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    up_we = 1'b0;
    lo_we = 1'b0;
    sl_we = 1'b0;
    ol_we = 1'b0;
    a_wa  = k[IW-1:0];
    b_wa  = k[IW-1:0];
    a_wd  = take_left ? rd0 : rd1;
    b_wd  = take_left ? rd0 : rd1;
    up_wd = (u != '0) ? IW'(u - CW'(1)) : '0;
    lo_wd = IW'(lp);
    sl_wa = k[IW-1:0];
    sl_wd = id;
    ol_wa = rd0[IW-1:0];
    ol_wd = CW'(sl_rd);
    unique case (cmd.op)
      OP_LOAD: begin
        a_we = (cnt_eff < MAX_COUNT);
        a_wa = IW'(cnt_eff);
        a_wd = {pv, IW'(cnt_eff)};
      end
      OP_SORT_WR: begin
        a_we = cur;
        b_we = !cur;
      end
      OP_UP_EV: begin
        up_we = !status.up_step;
      end
      OP_LO_EV: begin
        lo_we = !status.lo_step;
      end
      OP_CLR: begin
        sl_we = 1'b1;
        sl_wd = UNSEEN;
      end
      OP_SCAN_EV: begin
        sl_we = !status.visited;
        sl_wd = core ? (id + LW'(1)) : LW'(NOISE);
      end
      OP_GR_EV: begin
        sl_wa = i[IW-1:0];
        sl_we = (sl_rd == UNSEEN) || (sl_rd == LW'(NOISE));
      end
      OP_GL_EV: begin
        sl_wa = IW'(j - CW'(1));
        sl_we = (sl_rd == UNSEEN) || (sl_rd == LW'(NOISE));
      end
      OP_RO_WR: begin
        ol_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_we) buf_a[a_wa] <= a_wd;
    a_rd0 <= buf_a[addr0];
    a_rd1 <= buf_a[addr1];
  end

  always_ff @(posedge clk) begin
    if (b_we) buf_b[b_wa] <= b_wd;
    b_rd0 <= buf_b[addr0];
    b_rd1 <= buf_b[addr1];
  end

  always_ff @(posedge clk) begin
    if (up_we) upper_mem[k[IW-1:0]] <= up_wd;
    up_rd <= upper_mem[addr0];
  end

  always_ff @(posedge clk) begin
    if (lo_we) lower_mem[k[IW-1:0]] <= lo_wd;
    lo_rd <= lower_mem[addr0];
  end

  always_ff @(posedge clk) begin
    if (sl_we) slab_mem[sl_wa] <= sl_wd;
    sl_rd <= slab_mem[addr0];
  end

  always_ff @(posedge clk) begin
    if (ol_we) olab_mem[ol_wa] <= ol_wd;
    if (cmd.op == OP_QUERY) ol_rd <= olab_mem[IW'(in_data.query_index)];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.label       <= (cmd.op == OP_EMIT_QUERY && qok) ? 11'(ol_rd) : 11'(NOISE);
      out_data.point_count <= 11'(count);
      out_data.overflowed  <= ovf;
    end
  end

  // Set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      set_done <= 1'b0;
      id       <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          set_done <= 1'b0;
          if (cnt_eff < MAX_COUNT) begin
            count <= cnt_eff + CW'(1);
            if (set_done) ovf <= 1'b0;
          end else begin
            ovf <= 1'b1;
          end
        end
        OP_START:     id <= '0;
        OP_SCAN_EV:   if (!status.visited && core) id <= id + LW'(1);
        OP_EMIT_DONE: set_done <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Sweep counters and pointers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_QUERY: qok <= set_done && (32'(in_data.query_index) < 32'(count));
      OP_START: begin
        n   <= count;
        k   <= '0;
        u   <= '0;
        hi  <= '0;
        w   <= WW'(1);
        cur <= 1'b0;
      end
      OP_SORT_SEG: begin
        if (k == n) begin
          w   <= w << 1;
          cur <= !cur;
          k   <= '0;
          hi  <= '0;
          u   <= '0;
        end else if (k == hi) begin
          i   <= k;
          j   <= mid_c;
          mid <= mid_c;
          hi  <= hi_c;
        end
      end
      OP_SORT_WR: begin
        k <= k + CW'(1);
        if (take_left) i <= i + CW'(1);
        else j <= j + CW'(1);
      end
      OP_UP_EV: begin
        if (status.up_step) u <= u + CW'(1);
        else if (!status.k_last) k <= k + CW'(1);
        else lp <= n;
      end
      OP_LO_EV: begin
        if (status.lo_step) lp <= lp - CW'(1);
        else if (k != '0) k <= k - CW'(1);
      end
      OP_CLR: k <= status.k_last ? '0 : k + CW'(1);
      OP_SCAN_RD: if (status.k_end) k <= '0;
      OP_SCAN_EV: begin
        if (status.visited || !core) begin
          k <= k + CW'(1);
        end else begin
          p  <= k[IW-1:0];
          ru <= up_rd;
          rl <= lo_rd;
          i  <= k + CW'(1);
        end
      end
      OP_GR_RD: if (!status.gr_go) j <= CW'(p);
      OP_GR_EV: begin
        if (sl_rd == UNSEEN && core) ru <= up_rd;
        i <= i + CW'(1);
      end
      OP_GL_RD: if (!status.gl_go) k <= CW'(p) + CW'(1);
      OP_GL_EV: begin
        if (sl_rd == UNSEEN && core) rl <= lo_rd;
        j <= j - CW'(1);
      end
      OP_RO_WR: k <= k + CW'(1);
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/density_clustering_1d_core.sv @@
// Top level of the 1-D density clustering core.
// Holds the configuration registers and joins dc1d_controller and dc1d_datapath.
// Depends on dc1d_pkg, dc1d_controller, dc1d_datapath.
`default_nettype none

// Density clustering on a line. Load points one item at a time (func 0); the
// item marked last_point starts clustering of the held set and returns one item
// with label 0, the point count and the overflow flag. A load after a finished
// set starts a new set. Loads beyond MAX_POINTS are dropped and flag overflow.
// A query (func 1) returns the label of an arrival index: 0 for noise, k for
// cluster k, and 0 before a set is finished or past the point count.
// Clustering of n points is run by one state machine over single-ported-write
// memories with registered reads: a stable bottom-up merge sort over ceil(log2 n)
// passes (skipped when sort_enable is 0), the upper and lower two-pointer scans
// (at most 2n pointer moves each), the label clear, labeling and expansion, and
// the reorder to arrival order.
// Input is held off during clustering. Configuration writes are always taken,
// but the clustering passes read the registers directly: write them only while
// no item is in flight. A write applies to the next clustering.
module density_clustering_1d_core import dc1d_pkg::*; #(
  parameter int MAX_POINTS  = 1024,
  parameter int POINT_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire in_item_t                   in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output out_item_t                       out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0]                cfg_data
);

  logic [31:0] eps;
  logic [10:0] core_size;
  logic        sort_enable;
  cmd_t        cmd;
  status_t     status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps         <= EPS_RESET;
      core_size   <= CORE_SIZE_RESET;
      sort_enable <= SORT_ENABLE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EPS:         eps         <= cfg_data;
        CFG_CORE_SIZE:   core_size   <= cfg_data[10:0];
        CFG_SORT_ENABLE: sort_enable <= cfg_data[0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  dc1d_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .func       (in_data.func),
    .last_point (in_data.last_point),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  dc1d_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .POINT_WIDTH (POINT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_data     (in_data),
    .eps         (eps),
    .core_size   (core_size),
    .sort_enable (sort_enable),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .status      (status)
  );

  // A query item always holds off input for its read cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == FUNC_QUERY |=> !in_ready)
    else $error("input taken during query read");

  // Overflow is only reported with a full set
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflowed |-> out_data.point_count == 11'(MAX_POINTS))
    else $error("overflow reported without a full set");

  // A plain load never produces an item
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && in_ready && in_data.func == FUNC_LOAD
    && !in_data.last_point |=> !out_valid)
    else $error("item produced by a load without last mark");

endmodule

`default_nettype wire
